@@ rtl/btki_pkg.sv @@
// Shared types and constants for the bounded top-k sorted insertion list.
// Used by the controller, datapath, top level and checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package btki_pkg;

    // List storage depth and derived widths
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths fixed by the item format
    localparam int SCORE_W = 32;
    localparam int TAG_W   = 32;
    localparam int DATE_W  = 63;
    localparam int IDX_W   = 4;
    localparam int MAXE_W  = 5;

    // Reset value of the capacity register
    localparam logic [MAXE_W-1:0] MAXE_RESET = MAXE_W'(16);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CHECK  = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          tag;
        logic [DATE_W-1:0]         date_ms;
        logic [IDX_W-1:0]          index;
    } item_t;

    typedef struct packed {
        logic                      accepted;
        logic [IDX_W-1:0]          position;
        logic [MAXE_W-1:0]         count;
        logic                      entry_valid;
        logic signed [SCORE_W-1:0] entry_score;
        logic [TAG_W-1:0]          entry_tag;
        logic [DATE_W-1:0]         entry_date_ms;
    } result_t;

    // One stored list record
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          tag;
        logic [DATE_W-1:0]         date_ms;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DECODE = 2'd1,
        ST_WALK   = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic decode;
        logic walk;
        logic finish;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t  op;
        logic count_zero;
        logic greater;
        logic ptr_zero;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/btki_ctrl.sv @@
// Controller state machine for the top-k list: sequences decode, walk and finish.
// Depends on btki_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module btki_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire btki_pkg::dp_status_t status,
    output btki_pkg::ctl_cmd_t        cmd,
    output logic                      busy
);

    btki_pkg::state_t state_reg;
    btki_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btki_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btki_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = btki_pkg::ST_DECODE;
                end
            end
            btki_pkg::ST_DECODE:
            begin
                if (status.op == btki_pkg::OP_INSERT && !status.count_zero)
                begin
                    state_next = btki_pkg::ST_WALK;
                end
                else
                begin
                    state_next = btki_pkg::ST_FINISH;
                end
            end
            btki_pkg::ST_WALK:
            begin
                // Stop at the first entry not beaten, or past the head
                if (!status.greater || status.ptr_zero)
                begin
                    state_next = btki_pkg::ST_FINISH;
                end
            end
            btki_pkg::ST_FINISH:
            begin
                state_next = btki_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = btki_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            btki_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            btki_pkg::ST_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            btki_pkg::ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            btki_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/btki_dp.sv @@
// Datapath for the top-k list: entry memory, count, capacity, walk pointer, result.
// Depends on btki_pkg; driven by btki_ctrl through command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module btki_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire btki_pkg::item_t                       item,
    input  wire logic                                  cfg_we,
    input  wire logic [btki_pkg::MAXE_W-1:0]           cfg_wdata,
    input  wire btki_pkg::ctl_cmd_t                    cmd,
    output btki_pkg::dp_status_t                       status,
    output logic                                       done,
    output btki_pkg::result_t                          result
);

    localparam int AW = btki_pkg::ADDR_W;
    localparam int CW = btki_pkg::CNT_W;

    // Entry memory, one write and one registered read per cycle
    btki_pkg::entry_t mem [btki_pkg::DEPTH];
    btki_pkg::entry_t rdata_reg;

    btki_pkg::item_t                 item_reg;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic [btki_pkg::MAXE_W-1:0]     maxe_reg;
    logic [AW-1:0]                   ptr_reg;
    logic [CW-1:0]                   at_reg;
    btki_pkg::result_t               res_reg;
    btki_pkg::result_t               res_next;
    logic                            done_reg;

    logic [AW-1:0]                   rd_addr;
    logic [AW-1:0]                   wr_addr;
    btki_pkg::entry_t                wr_data;
    logic                            wr_en;

    logic [CW-1:0]                   cap;
    logic                            greater;
    logic                            room;
    logic                            place;
    logic [CW-1:0]                   count_inc;
    logic [CW-1:0]                   count_trunc;
    logic                            ins_ok;
    btki_pkg::entry_t                new_entry;

    // Capacity is the register clipped to the storage depth
    assign cap = (CW'(maxe_reg) < CW'(btki_pkg::DEPTH)) ? CW'(maxe_reg)
                                                         : CW'(btki_pkg::DEPTH);

    assign greater     = $signed(item_reg.score) > $signed(rdata_reg.score);
    assign room        = count_reg < cap;
    assign place       = at_reg < count_reg;
    assign count_inc   = count_reg + CW'(1);
    assign count_trunc = (count_inc < cap) ? count_inc : cap;
    assign ins_ok      = place ? (at_reg < count_trunc) : room;

    assign new_entry.score   = item_reg.score;
    assign new_entry.tag     = item_reg.tag;
    assign new_entry.date_ms = item_reg.date_ms;

    // Status back to the controller
    assign status.op         = item_reg.op;
    assign status.count_zero = (count_reg == '0);
    assign status.greater    = greater;
    assign status.ptr_zero   = (ptr_reg == '0);

    // Read address: last entry or read index at decode, one below the pointer in the walk
    always_comb
    begin
        rd_addr = ptr_reg - AW'(1);
        if (cmd.decode)
        begin
            if (item_reg.op == btki_pkg::OP_READ)
            begin
                rd_addr = AW'(item_reg.index);
            end
            else
            begin
                rd_addr = AW'(count_reg - CW'(1));
            end
        end
    end

    // Write port: shift an entry down during the walk, drop the new record at finish
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(at_reg);
        wr_data = new_entry;
        if (cmd.walk)
        begin
            wr_addr = ptr_reg + AW'(1);
            wr_data = rdata_reg;
            wr_en   = greater && (ptr_reg != AW'(btki_pkg::DEPTH - 1));
        end
        else if (cmd.finish && item_reg.op == btki_pkg::OP_INSERT)
        begin
            wr_en = place || room;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
    end

    // Result and new count for the finishing operation
    always_comb
    begin
        res_next   = '0;
        count_next = count_reg;
        case (item_reg.op)
            btki_pkg::OP_INSERT:
            begin
                if (place)
                begin
                    count_next = count_trunc;
                end
                else if (room)
                begin
                    count_next = count_inc;
                end
                res_next.accepted = ins_ok;
                res_next.position = ins_ok ? AW'(at_reg) : '0;
            end
            btki_pkg::OP_CHECK:
            begin
                res_next.accepted = ($signed(item_reg.score) > 0)
                                    && (room || (count_reg != '0 && greater));
            end
            btki_pkg::OP_READ:
            begin
                if (CW'(item_reg.index) < count_reg)
                begin
                    res_next.entry_valid   = 1'b1;
                    res_next.entry_score   = rdata_reg.score;
                    res_next.entry_tag     = rdata_reg.tag;
                    res_next.entry_date_ms = rdata_reg.date_ms;
                end
            end
            btki_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        res_next.count = btki_pkg::MAXE_W'(count_next);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            maxe_reg  <= btki_pkg::MAXE_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                maxe_reg <= cfg_wdata;
            end
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
            done_reg <= cmd.finish;
        end
    end

    // Payload registers: latched item, walk pointer, insertion point, result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.decode)
        begin
            ptr_reg <= AW'(count_reg - CW'(1));
            at_reg  <= count_reg;
        end
        else if (cmd.walk && greater)
        begin
            at_reg  <= CW'(ptr_reg);
            ptr_reg <= ptr_reg - AW'(1);
        end
        if (cmd.finish)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

@@ rtl/bounded_sorted_topk_insert.sv @@
// Bounded top-k list of score records kept in descending score order.
// A transaction is taken when start is high and busy is low; its result shows on
// result for exactly one cycle with done high, and the receiver cannot stall it.
// Check, read and clear pass through the decode and finish states; an insert into a
// non-empty list also passes through the walk state, comparing stored entries from
// the tail, one per cycle through the entry memory's single read port, until the
// insertion point is found. The entry memory needs no clearing after reset. The user
// must write max_entries through cfg_we/cfg_wdata only while the block is idle; the
// block itself does not enforce this. Depends on btki_pkg, btki_ctrl and btki_dp.
`timescale 1ns / 1ps
`default_nettype none

module bounded_sorted_topk_insert (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire btki_pkg::item_t               item,
    output logic                               done,
    output btki_pkg::result_t                  result,
    input  wire logic                          cfg_we,
    input  wire logic [btki_pkg::MAXE_W-1:0]   cfg_wdata
);

    btki_pkg::ctl_cmd_t   cmd;
    btki_pkg::dp_status_t status;

    // Sequence each transaction
    btki_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Hold the list and compute results
    btki_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ rtl/btki_checker.sv @@
// Port-level checker for bounded_sorted_topk_insert, attached by bind.
// Depends on btki_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module btki_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire btki_pkg::result_t  result
);

    // An accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted transaction");

    // A result appears exactly when the block goes idle
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("block went idle without a result");

    // No result while still busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Result strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Count never exceeds the storage depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.count <= btki_pkg::MAXE_W'(btki_pkg::DEPTH)))
        else $error("reported count beyond list depth");

endmodule

bind bounded_sorted_topk_insert btki_checker u_btki_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

@@ dv/bounded_sorted_topk_insert_test.sv @@
// Self-checking bench for the bounded top-k sorted insertion list.
// Holds a shadow copy of the list to predict each result; depends on btki_pkg
// and bounded_sorted_topk_insert.
`timescale 1ns / 1ps

module bounded_sorted_topk_insert_test;

    import btki_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    item_t             item = '0;
    logic              done;
    result_t           result;
    logic              cfg_we = 1'b0;
    logic [MAXE_W-1:0] cfg_wdata = '0;

    // Shadow list state and capacity register
    entry_t            shadow_list [DEPTH];
    int unsigned       shadow_count = 0;
    logic [MAXE_W-1:0] shadow_max = MAXE_RESET;

    item_t             op_backlog [$];
    result_t           outcome_queue [$];
    int                mismatches = 0;
    int                burst_left = 0;
    int                gap_left = 0;
    int unsigned       cycles = 0;

    bounded_sorted_topk_insert uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Apply one transaction to the shadow list and return the outcome it yields
    function automatic result_t apply_list_op(input item_t it);
        result_t     r;
        int unsigned cap;
        int unsigned n;
        int unsigned at;
        int unsigned j;
        int unsigned nn;
        bit          hit;
        r = '0;
        cap = (shadow_max < DEPTH) ? shadow_max : DEPTH;
        n = shadow_count;
        hit = 1'b0;
        at = n;
        case (it.op)
            OP_INSERT:
            begin
                // find the first stored entry with a strictly lower score
                for (int i = 0; i < n; i++)
                begin
                    if (!hit && $signed(it.score) > $signed(shadow_list[i].score))
                    begin
                        at = i;
                        hit = 1'b1;
                    end
                end
                if (at < n)
                begin
                    nn = (n + 1 < cap) ? n + 1 : cap;
                    for (j = (n < DEPTH) ? n : DEPTH - 1; j > at; j--)
                        shadow_list[j] = shadow_list[j-1];
                    shadow_list[at] = '{score: it.score, tag: it.tag, date_ms: it.date_ms};
                    shadow_count = nn;
                    if (at < nn)
                    begin
                        r.accepted = 1'b1;
                        r.position = IDX_W'(at);
                    end
                end
                else if (n < cap)
                begin
                    // append at the tail
                    shadow_list[n] = '{score: it.score, tag: it.tag, date_ms: it.date_ms};
                    shadow_count = n + 1;
                    r.accepted = 1'b1;
                    r.position = IDX_W'(n);
                end
            end
            OP_CHECK:
            begin
                if ($signed(it.score) > 0)
                begin
                    for (int i = 0; i < n; i++)
                        if ($signed(it.score) > $signed(shadow_list[i].score))
                            hit = 1'b1;
                    if (hit || n < cap)
                        r.accepted = 1'b1;
                end
            end
            OP_READ:
            begin
                if (it.index < n)
                begin
                    r.entry_valid   = 1'b1;
                    r.entry_score   = shadow_list[it.index].score;
                    r.entry_tag     = shadow_list[it.index].tag;
                    r.entry_date_ms = shadow_list[it.index].date_ms;
                end
            end
            default:
            begin
                shadow_count = 0;
            end
        endcase
        r.count = MAXE_W'(shadow_count);
        return r;
    endfunction

    task automatic note_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_op(input op_t op, input logic [31:0] score, input logic [31:0] tag,
                           input logic [62:0] date, input logic [3:0] index);
        item_t it;
        it.op      = op;
        it.score   = score;
        it.tag     = tag;
        it.date_ms = date;
        it.index   = index;
        op_backlog = {op_backlog, it};
    endtask

    // Scores cluster on a small range so that ties and reorders are frequent
    function automatic logic [31:0] pick_score();
        logic [31:0] s;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: s = 32'h8000_0000;
                    1: s = 32'h7fff_ffff;
                    2: s = 32'h0000_0000;
                    3: s = 32'h0000_0001;
                    default: s = 32'hffff_ffff;
                endcase
            end
            1, 2: s = $urandom;
            default:
            begin
                s = $urandom_range(0, 12);
                s = s - 32'd4;
            end
        endcase
        return s;
    endfunction

    function automatic item_t random_op();
        item_t       it;
        logic [63:0] d;
        int          r;
        r = $urandom_range(0, 19);
        if (r < 10)
            it.op = OP_INSERT;
        else if (r < 14)
            it.op = OP_CHECK;
        else if (r < 19)
            it.op = OP_READ;
        else
            it.op = OP_CLEAR;
        d = {$urandom, $urandom};
        it.score   = pick_score();
        it.tag     = $urandom;
        it.date_ms = d[62:0];
        it.index   = IDX_W'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic queue_random_ops(input int n_ops);
        int          made;
        int          run;
        item_t       it;
        made = 0;
        while (made < n_ops)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // fill run: a stretch of inserts to reach a full list
                run = $urandom_range(4, 18);
                for (int k = 0; k < run; k++)
                begin
                    it = random_op();
                    it.op = OP_INSERT;
                    op_backlog = {op_backlog, it};
                    made++;
                end
            end
            else
            begin
                it = random_op();
                op_backlog = {op_backlog, it};
                made++;
            end
        end
    endtask

    // Hold until nothing is queued, in flight or outstanding
    task automatic wait_drained();
        do
            @(negedge clk);
        while (op_backlog.size() != 0 || start || outcome_queue.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [MAXE_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        shadow_max = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Driver: present queued transactions in bursts separated by random gaps
    always @(posedge clk)
    begin : drive_proc
        logic    next_start;
        result_t predicted;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predicted = apply_list_op(item);
                outcome_queue = {outcome_queue, predicted};
            end
            next_start = start && busy;
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (op_backlog.size() > 0)
                begin
                    item <= op_backlog.pop_front();
                    next_start = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end
                end
            end
            start <= next_start;
        end
    end

    // Monitor: compare each strobed result with the oldest prediction
    always @(posedge clk)
    begin : check_proc
        result_t want;
        if (rst_n && done)
        begin
            if (outcome_queue.size() == 0)
            begin
                $display("%0t: unexpected result expected none got %0h", $time, result);
                mismatches++;
            end
            else
            begin
                want = outcome_queue.pop_front();
                note_field("accepted", want.accepted, result.accepted);
                note_field("position", want.position, result.position);
                note_field("count", want.count, result.count);
                note_field("entry_valid", want.entry_valid, result.entry_valid);
                note_field("entry_score", want.entry_score, result.entry_score);
                note_field("entry_tag", want.entry_tag, result.entry_tag);
                note_field("entry_date_ms", want.entry_date_ms, result.entry_date_ms);
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin : limit_proc
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [MAXE_W-1:0] caps [8];
        caps = '{5'd31, 5'd16, 5'd0, 5'd1, 5'd0, 5'd17, 5'd7, 5'd0};
        caps[4] = MAXE_W'($urandom_range(0, 31));
        caps[7] = MAXE_W'($urandom_range(0, 31));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty list, check thresholds, extremes, equal scores, reads past count
        push_op(OP_READ, 32'd0, 32'd0, 63'd0, 4'd0);
        push_op(OP_CHECK, 32'd1, 32'd0, 63'd0, 4'd0);
        push_op(OP_CHECK, 32'd0, 32'd0, 63'd0, 4'd0);
        push_op(OP_CHECK, 32'h8000_0000, 32'd0, 63'd0, 4'd0);
        push_op(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff, {63{1'b1}}, 4'hf);
        push_op(OP_INSERT, 32'h8000_0000, 32'd0, 63'd0, 4'd0);
        push_op(OP_INSERT, 32'd5, 32'd11, 63'd100, 4'd3);
        push_op(OP_INSERT, 32'd5, 32'd12, 63'd200, 4'd5);
        push_op(OP_INSERT, 32'd0, 32'd13, 63'd300, 4'd0);
        push_op(OP_READ, 32'd0, 32'd0, 63'd0, 4'd1);
        push_op(OP_READ, 32'd0, 32'd0, 63'd0, 4'd2);
        push_op(OP_READ, 32'd0, 32'd0, 63'd0, 4'd4);
        push_op(OP_READ, 32'd0, 32'd0, 63'd0, 4'd15);
        push_op(OP_CHECK, 32'hffff_ffff, 32'd0, 63'd0, 4'd0);
        push_op(OP_CLEAR, 32'd0, 32'd0, 63'd0, 4'd0);
        wait_drained();

        // Zero capacity: nothing enters, nothing qualifies
        write_capacity(5'd0);
        push_op(OP_INSERT, 32'd7, 32'd1, 63'd1, 4'd0);
        push_op(OP_CHECK, 32'd7, 32'd0, 63'd0, 4'd0);
        wait_drained();

        // Full list drops its tail; a low score finds no room
        write_capacity(5'd4);
        push_op(OP_INSERT, 32'd10, 32'd21, 63'd1, 4'd0);
        push_op(OP_INSERT, 32'd20, 32'd22, 63'd2, 4'd0);
        push_op(OP_INSERT, 32'd30, 32'd23, 63'd3, 4'd0);
        push_op(OP_INSERT, 32'd40, 32'd24, 63'd4, 4'd0);
        push_op(OP_INSERT, 32'd25, 32'd25, 63'd5, 4'd0);
        push_op(OP_INSERT, 32'd5, 32'd26, 63'd6, 4'd0);
        wait_drained();

        // Capacity lowered below count: an insert truncates and may not survive
        write_capacity(5'd2);
        push_op(OP_CHECK, 32'd1, 32'd0, 63'd0, 4'd0);
        push_op(OP_INSERT, 32'd22, 32'd27, 63'd7, 4'd0);
        push_op(OP_READ, 32'd0, 32'd0, 63'd0, 4'd1);
        push_op(OP_READ, 32'd0, 32'd0, 63'd0, 4'd2);
        wait_drained();

        // Random phases, one capacity setting each
        foreach (caps[p])
        begin
            write_capacity(caps[p]);
            queue_random_ops(165);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (outcome_queue.size() != 0)
        begin
            $display("%0t: %0d results expected got none", $time, outcome_queue.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
